// ===== hw/rtl/tcce_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package tcce_pkg;

   // Screen geometry limits and tab spacing (tab spacing is a power of two)
   localparam int MAX_COLS = 128;
   localparam int MAX_ROWS = 64;
   localparam int TAB_STOP = 8;
   localparam int TAB_LOG  = $clog2(TAB_STOP);
   localparam int TAB_W    = $clog2(TAB_STOP + 1);

   localparam int COL_W     = 7;
   localparam int ROW_W     = 6;
   localparam int GLYPH_W   = 7;
   localparam int COLOR_W   = 32;
   localparam int COLS_REG_W = 8;
   localparam int ROWS_REG_W = 7;
   localparam int CSR_IDX_W = 3;

   localparam int CMD_DEPTH = 4;
   localparam int RSP_DEPTH = 4;

   localparam logic [COLS_REG_W-1:0] COLUMNS_RESET = 8'd80;
   localparam logic [ROWS_REG_W-1:0] ROWS_RESET    = 7'd25;
   localparam logic [COLOR_W-1:0]    FORE_RESET    = 32'h00FF_FFFF;
   localparam logic [COLOR_W-1:0]    BACK_RESET    = 32'h0000_0000;

   // Register indexes on the configuration port
   localparam logic [CSR_IDX_W-1:0] CSR_COLUMNS    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROWS       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_FORE_COLOR = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BACK_COLOR = 3'd3;

   // Command actions
   localparam logic [2:0] ACT_PUT   = 3'd0;
   localparam logic [2:0] ACT_LEFT  = 3'd1;
   localparam logic [2:0] ACT_RIGHT = 3'd2;
   localparam logic [2:0] ACT_SHOW  = 3'd3;
   localparam logic [2:0] ACT_CLEAR = 3'd4;

   // Control characters and the printable range
   localparam logic [7:0] CHAR_BS    = 8'd8;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_NL    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_FIRST = 8'd32;
   localparam logic [7:0] CHAR_LAST  = 8'd126;

   typedef enum logic [2:0] {
      OP_GLYPH    = 3'd0,
      OP_BLANK    = 3'd1,
      OP_ERASE_UL = 3'd2,
      OP_DRAW_UL  = 3'd3,
      OP_SCROLL   = 3'd4,
      OP_CLEAR    = 3'd5,
      OP_NONE     = 3'd6
   } op_type;

   typedef enum logic [3:0] {
      CMD_GLYPH,
      CMD_NEWLINE,
      CMD_RETURN,
      CMD_BACKSPACE,
      CMD_TAB,
      CMD_LEFT,
      CMD_RIGHT,
      CMD_SHOW,
      CMD_CLEAR,
      CMD_NOP
   } cmd_kind_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_BLANK,
      ST_SCROLL
   } state_type;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] char_code;
   } req_type;

   typedef struct packed {
      op_type             op;
      logic [COL_W-1:0]   cell_col;
      logic [ROW_W-1:0]   cell_row;
      logic [GLYPH_W-1:0] glyph_index;
      logic [COLOR_W-1:0] fg_out;
      logic [COLOR_W-1:0] bg_out;
      logic               last;
   } rsp_type;

   typedef struct packed {
      cmd_kind_type       kind;
      logic [GLYPH_W-1:0] glyph;
   } cmd_type;

   // Effective geometry and colours seen by the back end
   typedef struct packed {
      logic [COLS_REG_W-1:0] cols;
      logic [ROWS_REG_W-1:0] rows;
      logic [COLOR_W-1:0]    fore;
      logic [COLOR_W-1:0]    back;
   } cfg_type;

endpackage

`default_nettype wire

// ===== hw/rtl/tcce_fifo.sv =====
`timescale 1ns / 1ps
`default_nettype none

// DEPTH must be at least 2
module tcce_fifo #(
   parameter int WIDTH = $bits(tcce_pkg::rsp_type),
   parameter int DEPTH = tcce_pkg::RSP_DEPTH
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  full,
   input  wire logic             pop,
   output logic [WIDTH-1:0]      pop_data,
   output logic                  empty
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tcce_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcce_front (
   input  wire logic              req_push,
   input  wire tcce_pkg::req_type req_data,
   output logic                   req_full,
   input  wire logic              cmd_full,
   output logic                   cmd_push,
   output tcce_pkg::cmd_type      cmd_data
);

   logic [7:0] ch;
   logic       printable;

   assign ch        = req_data.char_code;
   assign printable = (ch >= tcce_pkg::CHAR_FIRST) && (ch <= tcce_pkg::CHAR_LAST);
   assign req_full  = cmd_full;
   assign cmd_push  = req_push && !cmd_full;

   always_comb begin
      cmd_data.glyph = printable ? tcce_pkg::GLYPH_W'(ch - tcce_pkg::CHAR_FIRST) : '0;
      unique case (req_data.action)
         tcce_pkg::ACT_PUT: begin
            priority if (ch == tcce_pkg::CHAR_NL) begin
               cmd_data.kind = tcce_pkg::CMD_NEWLINE;
            end else if (ch == tcce_pkg::CHAR_CR) begin
               cmd_data.kind = tcce_pkg::CMD_RETURN;
            end else if (ch == tcce_pkg::CHAR_BS) begin
               cmd_data.kind = tcce_pkg::CMD_BACKSPACE;
            end else if (ch == tcce_pkg::CHAR_TAB) begin
               cmd_data.kind = tcce_pkg::CMD_TAB;
            end else begin
               cmd_data.kind = tcce_pkg::CMD_GLYPH;
            end
         end
         tcce_pkg::ACT_LEFT:  cmd_data.kind = tcce_pkg::CMD_LEFT;
         tcce_pkg::ACT_RIGHT: cmd_data.kind = tcce_pkg::CMD_RIGHT;
         tcce_pkg::ACT_SHOW:  cmd_data.kind = tcce_pkg::CMD_SHOW;
         tcce_pkg::ACT_CLEAR: cmd_data.kind = tcce_pkg::CMD_CLEAR;
         default:             cmd_data.kind = tcce_pkg::CMD_NOP;
      endcase
   end

endmodule

`default_nettype wire

// ===== hw/rtl/tcce_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcce_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire tcce_pkg::cfg_type cfg,
   input  wire logic              cmd_empty,
   input  wire tcce_pkg::cmd_type cmd_data,
   output logic                   cmd_pop,
   input  wire logic              rsp_full,
   output logic                   rsp_push,
   output tcce_pkg::rsp_type      rsp_data
);

   typedef struct packed {
      logic [tcce_pkg::COL_W-1:0] col;
      logic [tcce_pkg::ROW_W-1:0] row;
      logic                       scroll;
   } settle_type;

   tcce_pkg::state_type    state_ff, state_in;
   tcce_pkg::cmd_kind_type kind_ff;
   logic [tcce_pkg::GLYPH_W-1:0] glyph_ff;
   logic [tcce_pkg::COL_W-1:0]   col_ff, col_in;
   logic [tcce_pkg::ROW_W-1:0]   row_ff, row_in;
   logic [tcce_pkg::TAB_W-1:0]   tab_left_ff, tab_left_in;

   logic [tcce_pkg::COL_W:0] col_inc, col_dec;
   logic [tcce_pkg::ROW_W:0] row_ext;
   logic                     advance;
   logic                     scroll_pend, go_blank, stay_exec;
   settle_type               s_inc, s_dec, s_nl, s_cr;

   // Wrap the column, then scroll if the row has run off the screen
   function automatic settle_type settle(
      input logic [tcce_pkg::COL_W:0]        ncol,
      input logic [tcce_pkg::ROW_W:0]        nrow,
      input logic [tcce_pkg::COLS_REG_W-1:0] cols,
      input logic [tcce_pkg::ROWS_REG_W-1:0] rows
   );
      settle_type               s;
      logic [tcce_pkg::ROW_W:0] r;
      r     = nrow;
      s.col = ncol[tcce_pkg::COL_W-1:0];
      if (ncol >= cols) begin
         s.col = '0;
         r     = nrow + 1'b1;
      end
      s.scroll = (r >= rows);
      s.row    = s.scroll ? tcce_pkg::ROW_W'(rows - 1'b1) : r[tcce_pkg::ROW_W-1:0];
      return s;
   endfunction

   assign col_inc  = {1'b0, col_ff} + 1'b1;
   assign col_dec  = {1'b0, col_ff} - 1'b1;
   assign row_ext  = {1'b0, row_ff};
   assign s_inc    = settle(col_inc, row_ext, cfg.cols, cfg.rows);
   assign s_dec    = settle(col_dec, row_ext, cfg.cols, cfg.rows);
   assign s_nl     = settle('0, row_ext + 1'b1, cfg.cols, cfg.rows);
   assign s_cr     = settle('0, row_ext, cfg.cols, cfg.rows);

   assign cmd_pop  = (state_ff == tcce_pkg::ST_IDLE) && !cmd_empty;
   assign rsp_push = (state_ff != tcce_pkg::ST_IDLE);
   assign advance  = rsp_push && !rsp_full;

   // Transaction contents and cursor updates
   always_comb begin
      rsp_data             = '0;
      rsp_data.op          = tcce_pkg::OP_NONE;
      rsp_data.last        = 1'b1;
      col_in               = col_ff;
      row_in               = row_ff;
      tab_left_in          = tab_left_ff;
      scroll_pend          = 1'b0;
      go_blank             = 1'b0;
      stay_exec            = 1'b0;
      unique case (state_ff)
         tcce_pkg::ST_EXEC: begin
            unique case (kind_ff)
               tcce_pkg::CMD_GLYPH, tcce_pkg::CMD_TAB: begin
                  rsp_data.op          = tcce_pkg::OP_GLYPH;
                  rsp_data.cell_col    = col_ff;
                  rsp_data.cell_row    = row_ff;
                  rsp_data.glyph_index = (kind_ff == tcce_pkg::CMD_TAB) ? '0 : glyph_ff;
                  rsp_data.fg_out      = cfg.fore;
                  rsp_data.bg_out      = cfg.back;
                  col_in               = s_inc.col;
                  row_in               = s_inc.row;
                  scroll_pend          = s_inc.scroll;
                  if (kind_ff == tcce_pkg::CMD_TAB) begin
                     tab_left_in   = tab_left_ff - 1'b1;
                     stay_exec     = !s_inc.scroll && (tab_left_in != '0);
                     rsp_data.last = !s_inc.scroll && (tab_left_in == '0);
                  end else begin
                     rsp_data.last = !s_inc.scroll;
                  end
               end
               tcce_pkg::CMD_NEWLINE, tcce_pkg::CMD_RETURN, tcce_pkg::CMD_BACKSPACE: begin
                  if (kind_ff == tcce_pkg::CMD_BACKSPACE && col_ff != '0) begin
                     rsp_data.op       = tcce_pkg::OP_ERASE_UL;
                     rsp_data.cell_col = col_ff;
                     rsp_data.cell_row = row_ff;
                     rsp_data.fg_out   = cfg.back;
                     rsp_data.bg_out   = cfg.back;
                     rsp_data.last     = 1'b0;
                     go_blank          = 1'b1;
                  end else begin
                     // Column drops to zero; the scroll, if any, is the only op
                     col_in = '0;
                     if (kind_ff == tcce_pkg::CMD_NEWLINE) begin
                        row_in = s_nl.row;
                        if (s_nl.scroll) begin
                           rsp_data.op     = tcce_pkg::OP_SCROLL;
                           rsp_data.fg_out = cfg.back;
                           rsp_data.bg_out = cfg.back;
                        end
                     end else begin
                        row_in = s_cr.row;
                        if (s_cr.scroll) begin
                           rsp_data.op     = tcce_pkg::OP_SCROLL;
                           rsp_data.fg_out = cfg.back;
                           rsp_data.bg_out = cfg.back;
                        end
                     end
                  end
               end
               tcce_pkg::CMD_LEFT: begin
                  if (col_ff != '0) begin
                     rsp_data.op       = tcce_pkg::OP_ERASE_UL;
                     rsp_data.cell_col = col_ff;
                     rsp_data.cell_row = row_ff;
                     rsp_data.fg_out   = cfg.back;
                     rsp_data.bg_out   = cfg.back;
                     col_in            = col_dec[tcce_pkg::COL_W-1:0];
                  end
               end
               tcce_pkg::CMD_RIGHT: begin
                  if (col_inc < cfg.cols) begin
                     rsp_data.op       = tcce_pkg::OP_ERASE_UL;
                     rsp_data.cell_col = col_ff;
                     rsp_data.cell_row = row_ff;
                     rsp_data.fg_out   = cfg.back;
                     rsp_data.bg_out   = cfg.back;
                     col_in            = col_inc[tcce_pkg::COL_W-1:0];
                  end
               end
               tcce_pkg::CMD_SHOW: begin
                  rsp_data.op       = tcce_pkg::OP_DRAW_UL;
                  rsp_data.cell_col = col_ff;
                  rsp_data.cell_row = row_ff;
                  rsp_data.fg_out   = cfg.fore;
                  rsp_data.bg_out   = cfg.back;
               end
               tcce_pkg::CMD_CLEAR: begin
                  rsp_data.op     = tcce_pkg::OP_CLEAR;
                  rsp_data.fg_out = cfg.back;
                  rsp_data.bg_out = cfg.back;
                  col_in          = '0;
                  row_in          = '0;
               end
               default: begin
                  rsp_data.op = tcce_pkg::OP_NONE;
               end
            endcase
         end
         tcce_pkg::ST_BLANK: begin
            rsp_data.op       = tcce_pkg::OP_BLANK;
            rsp_data.cell_col = col_dec[tcce_pkg::COL_W-1:0];
            rsp_data.cell_row = row_ff;
            rsp_data.fg_out   = cfg.back;
            rsp_data.bg_out   = cfg.back;
            rsp_data.last     = !s_dec.scroll;
            col_in            = s_dec.col;
            row_in            = s_dec.row;
            scroll_pend       = s_dec.scroll;
         end
         tcce_pkg::ST_SCROLL: begin
            // Cursor already moved when the scroll was raised
            rsp_data.op     = tcce_pkg::OP_SCROLL;
            rsp_data.fg_out = cfg.back;
            rsp_data.bg_out = cfg.back;
            stay_exec       = (kind_ff == tcce_pkg::CMD_TAB) && (tab_left_ff != '0);
            rsp_data.last   = !stay_exec;
         end
         default: begin
            rsp_data.op = tcce_pkg::OP_NONE;
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tcce_pkg::ST_IDLE: begin
            if (!cmd_empty) state_in = tcce_pkg::ST_EXEC;
         end
         tcce_pkg::ST_EXEC, tcce_pkg::ST_BLANK, tcce_pkg::ST_SCROLL: begin
            if (advance) begin
               priority if (go_blank) begin
                  state_in = tcce_pkg::ST_BLANK;
               end else if (scroll_pend) begin
                  state_in = tcce_pkg::ST_SCROLL;
               end else if (stay_exec) begin
                  state_in = tcce_pkg::ST_EXEC;
               end else begin
                  state_in = tcce_pkg::ST_IDLE;
               end
            end
         end
         default: state_in = tcce_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tcce_pkg::ST_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
      end else begin
         state_ff <= state_in;
         if (advance) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd_pop) begin
         kind_ff     <= cmd_data.kind;
         glyph_ff    <= cmd_data.glyph;
         tab_left_ff <= tcce_pkg::TAB_W'(tcce_pkg::TAB_STOP)
                        - tcce_pkg::TAB_W'(col_ff[tcce_pkg::TAB_LOG-1:0]);
      end else if (advance) begin
         tab_left_ff <= tab_left_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/text_console_cursor_engine.sv =====
// A command passes through the command queue, the back end and the response queue.
// The back end fetches each command while idle, then emits one result per cycle unless the
//   response queue is full; a tab emits a blank glyph per column up to the next tab stop.
// The command queue takes new commands while the back end is busy, up to CMD_DEPTH.
// Reset clears the cursor to (0,0), empties both queues and reloads the register defaults.
`timescale 1ns / 1ps
`default_nettype none

module text_console_cursor_engine #(
   parameter int CMD_DEPTH = tcce_pkg::CMD_DEPTH,
   parameter int RSP_DEPTH = tcce_pkg::RSP_DEPTH
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_push,
   input  wire tcce_pkg::req_type                  req_data,
   output logic                                    req_full,
   output logic                                    rsp_empty,
   input  wire logic                               rsp_pop,
   output tcce_pkg::rsp_type                       rsp_data,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic [tcce_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [tcce_pkg::COLOR_W-1:0]       csr_data
);

   localparam int CMD_W = $bits(tcce_pkg::cmd_type);
   localparam int RSP_W = $bits(tcce_pkg::rsp_type);

   logic [tcce_pkg::COLS_REG_W-1:0] columns_ff;
   logic [tcce_pkg::ROWS_REG_W-1:0] rows_ff;
   logic [tcce_pkg::COLOR_W-1:0]    fore_ff, back_ff;
   tcce_pkg::cfg_type               cfg;

   logic              cmd_push, cmd_full, cmd_empty, cmd_pop;
   tcce_pkg::cmd_type cmd_in, cmd_head;
   logic [CMD_W-1:0]  cmd_head_vec;
   logic              back_push, back_full;
   tcce_pkg::rsp_type back_rsp;
   logic [RSP_W-1:0]  rsp_vec;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= tcce_pkg::COLUMNS_RESET;
         rows_ff    <= tcce_pkg::ROWS_RESET;
         fore_ff    <= tcce_pkg::FORE_RESET;
         back_ff    <= tcce_pkg::BACK_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            tcce_pkg::CSR_COLUMNS:    columns_ff <= csr_data[tcce_pkg::COLS_REG_W-1:0];
            tcce_pkg::CSR_ROWS:       rows_ff    <= csr_data[tcce_pkg::ROWS_REG_W-1:0];
            tcce_pkg::CSR_FORE_COLOR: fore_ff    <= csr_data;
            tcce_pkg::CSR_BACK_COLOR: back_ff    <= csr_data;
            default: ;
         endcase
      end
   end

   // Saturate the geometry to 1..max
   always_comb begin
      priority if (columns_ff == '0) begin
         cfg.cols = tcce_pkg::COLS_REG_W'(1);
      end else if (columns_ff > tcce_pkg::COLS_REG_W'(tcce_pkg::MAX_COLS)) begin
         cfg.cols = tcce_pkg::COLS_REG_W'(tcce_pkg::MAX_COLS);
      end else begin
         cfg.cols = columns_ff;
      end
      priority if (rows_ff == '0) begin
         cfg.rows = tcce_pkg::ROWS_REG_W'(1);
      end else if (rows_ff > tcce_pkg::ROWS_REG_W'(tcce_pkg::MAX_ROWS)) begin
         cfg.rows = tcce_pkg::ROWS_REG_W'(tcce_pkg::MAX_ROWS);
      end else begin
         cfg.rows = rows_ff;
      end
      cfg.fore = fore_ff;
      cfg.back = back_ff;
   end

   tcce_front u_front (
      .req_push (req_push),
      .req_data (req_data),
      .req_full (req_full),
      .cmd_full (cmd_full),
      .cmd_push (cmd_push),
      .cmd_data (cmd_in)
   );

   tcce_fifo #(
      .WIDTH (CMD_W),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_head_vec),
      .empty     (cmd_empty)
   );

   assign cmd_head = tcce_pkg::cmd_type'(cmd_head_vec);

   tcce_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .cmd_empty (cmd_empty),
      .cmd_data  (cmd_head),
      .cmd_pop   (cmd_pop),
      .rsp_full  (back_full),
      .rsp_push  (back_push),
      .rsp_data  (back_rsp)
   );

   tcce_fifo #(
      .WIDTH (RSP_W),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (back_push),
      .push_data (back_rsp),
      .full      (back_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_vec),
      .empty     (rsp_empty)
   );

   assign rsp_data = tcce_pkg::rsp_type'(rsp_vec);

endmodule

`default_nettype wire

// ===== hw/rtl/tcce_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module tcce_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_full,
   input wire logic              rsp_empty,
   input wire logic              rsp_pop,
   input wire tcce_pkg::rsp_type rsp_data
);

   // Both queues come out of reset empty
   a_reset_empty : assert property (@(posedge clock)
      reset |=> rsp_empty && !req_full)
      else $error("queues not empty after reset");

   a_none_clean : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.op == tcce_pkg::OP_NONE) |->
         (rsp_data.last && rsp_data.fg_out == '0 && rsp_data.bg_out == '0
          && rsp_data.cell_col == '0 && rsp_data.cell_row == '0))
      else $error("no-op transaction carries data or is not last");

   a_screen_ops : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && (rsp_data.op == tcce_pkg::OP_SCROLL
                      || rsp_data.op == tcce_pkg::OP_CLEAR)) |->
         (rsp_data.cell_col == '0 && rsp_data.cell_row == '0
          && rsp_data.fg_out == rsp_data.bg_out))
      else $error("scroll or clear with cell position or mixed colours");

   a_glyph_only : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && rsp_data.op != tcce_pkg::OP_GLYPH) |-> (rsp_data.glyph_index == '0))
      else $error("glyph index set on a non-glyph transaction");

   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)))
      else $error("waiting transaction changed or vanished");

endmodule

bind text_console_cursor_engine tcce_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .req_full  (req_full),
   .rsp_empty (rsp_empty),
   .rsp_pop   (rsp_pop),
   .rsp_data  (rsp_data)
);

`default_nettype wire
